// ===== hdl/kmds_pkg.sv =====
// Shared types and constants for the key matrix debounce scanner.
package kmds_pkg;

    // Default matrix geometry
    localparam int ROWS_DEF    = 5;
    localparam int COLUMNS_DEF = 4;

    // Fixed field widths
    localparam int COL_W  = 2;
    localparam int PIN_W  = 5;
    localparam int TIME_W = 32;
    localparam int KEY_W  = 5;
    localparam int DEB_W  = 8;

    // Debounce register value after reset
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd7;

    // Depth of the scan queue and of the event queue
    localparam int QUEUE_DEPTH = 2;

    // One accepted column scan
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [PIN_W-1:0]  row_pins;
        logic [TIME_W-1:0] now_ms;
    } t_scan;

    // One key event
    typedef struct packed {
        logic [KEY_W-1:0] key_number;
        logic             pressed;
        logic             last_event;
    } t_event;

    // Back end sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } t_back_state;

endpackage

// ===== hdl/kmds_fifo.sv =====
// Small flop-based queue used between the scanner stages and at the result side.
module kmds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_store[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/kmds_front.sv =====
// Front end: takes column scans, drops scans of columns outside the matrix.
module kmds_front #(
    parameter int COLUMNS = kmds_pkg::COLUMNS_DEF
) (
    input  logic                        push,
    output logic                        full,
    input  logic [kmds_pkg::COL_W-1:0]  i_column,
    input  logic [kmds_pkg::PIN_W-1:0]  i_row_pins,
    input  logic [kmds_pkg::TIME_W-1:0] i_now_ms,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output kmds_pkg::t_scan             o_q_data
);
    import kmds_pkg::*;

    logic w_col_ok;

    // A scan is taken whenever the queue has room; only valid columns go on
    assign w_col_ok = ((COL_W+4)'(i_column) < (COL_W+4)'(COLUMNS));
    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full && w_col_ok;

    always_comb begin
        o_q_data.column   = i_column;
        o_q_data.row_pins = i_row_pins;
        o_q_data.now_ms   = i_now_ms;
    end

endmodule

// ===== hdl/kmds_back.sv =====
// Back end: per-key debounce state, evaluation of a column and event emission.
module kmds_back #(
    parameter int ROWS    = kmds_pkg::ROWS_DEF,
    parameter int COLUMNS = kmds_pkg::COLUMNS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [kmds_pkg::DEB_W-1:0] i_debounce_ms,
    input  logic                       i_q_empty,
    input  kmds_pkg::t_scan            i_q_data,
    output logic                       o_q_pop,
    input  logic                       i_ev_full,
    output logic                       o_ev_push,
    output kmds_pkg::t_event           o_ev
);
    import kmds_pkg::*;

    localparam int CW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KNW = 8;

    // Change times, one memory row per column
    logic [ROWS*TIME_W-1:0]          r_mem [COLUMNS];
    logic [COLUMNS-1:0]              r_col_valid;
    logic [COLUMNS-1:0][ROWS-1:0]    r_prev;
    logic [COLUMNS-1:0][ROWS-1:0]    r_stable;

    t_back_state                     r_state;
    t_back_state                     n_state;
    t_scan                           r_scan;
    logic [ROWS*TIME_W-1:0]          r_ct_row;
    logic                            r_row_ok;
    logic [ROWS-1:0]                 r_ev_mask;
    logic [ROWS-1:0]                 r_read;

    logic [CW-1:0]                   w_q_col;
    logic [CW-1:0]                   w_col;
    logic [ROWS+PIN_W-1:0]           w_pins_ext;
    logic [ROWS-1:0]                 w_rd;
    logic [ROWS*TIME_W-1:0]          w_new_row;
    logic [ROWS-1:0]                 w_ev;
    logic [TIME_W-1:0]               w_ct;
    logic [TIME_W-1:0]               w_new_ct;
    logic [TIME_W-1:0]               w_elapsed;
    logic [RW-1:0]                   w_low;
    logic [ROWS-1:0]                 w_rest;
    logic [KNW-1:0]                  w_key;
    logic                            w_eval;

    assign w_q_col    = CW'(i_q_data.column);
    assign w_col      = CW'(r_scan.column);
    assign w_pins_ext = {{ROWS{1'b0}}, r_scan.row_pins};
    assign w_eval     = (r_state == S_EVAL);

    // Readings, new change times and event flags for all rows of the column
    always_comb begin
        w_ct      = '0;
        w_new_ct  = '0;
        w_elapsed = '0;
        for (int r = 0; r < ROWS; r++) begin
            w_rd[r]   = ~w_pins_ext[r];
            w_ct      = r_row_ok ? r_ct_row[r*TIME_W +: TIME_W] : '0;
            w_new_ct  = (w_rd[r] != r_prev[w_col][r]) ? r_scan.now_ms : w_ct;
            w_elapsed = r_scan.now_ms - w_new_ct;
            w_new_row[r*TIME_W +: TIME_W] = w_new_ct;
            w_ev[r]   = (w_elapsed > {{(TIME_W-DEB_W){1'b0}}, i_debounce_ms})
                        && (w_rd[r] != r_stable[w_col][r]);
        end
    end

    // Lowest pending event row
    always_comb begin
        w_low = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (r_ev_mask[r]) begin
                w_low = RW'(r);
            end
        end
        w_rest = r_ev_mask & ~(ROWS'(1) << w_low);
        w_key  = KNW'(w_low) + KNW'(r_scan.column) * KNW'(ROWS);
    end

    always_comb begin
        o_ev.key_number = w_key[KEY_W-1:0];
        o_ev.pressed    = r_read[w_low];
        o_ev.last_event = (w_rest == '0);
    end

    // Sequencer next state and handshakes
    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        o_ev_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = (w_ev == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (!i_ev_full) begin
                    o_ev_push = 1'b1;
                    if (w_rest == '0) begin
                        if (!i_q_empty) begin
                            o_q_pop = 1'b1;
                            n_state = S_EVAL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-key state flops and pending event mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= '0;
            r_prev      <= '0;
            r_stable    <= '0;
            r_ev_mask   <= '0;
        end else if (w_eval) begin
            r_col_valid[w_col] <= 1'b1;
            r_prev[w_col]      <= w_rd;
            r_stable[w_col]    <= r_stable[w_col] ^ w_ev;
            r_ev_mask          <= w_ev;
        end else if (o_ev_push) begin
            r_ev_mask <= w_rest;
        end
    end

    // Change time memory, scan latch and registered row read
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_mem[w_col] <= w_new_row;
            r_read       <= w_rd;
        end
        if (o_q_pop) begin
            r_scan   <= i_q_data;
            r_ct_row <= r_mem[w_q_col];
            r_row_ok <= r_col_valid[w_q_col];
        end
    end

endmodule

// ===== hdl/key_matrix_debounce_scanner.sv =====
// Top level of the key matrix debounce scanner.
//
// Usage: each column scan (column, row_pins, now_ms) is pushed through the
// input queue port (push/full); a scan is taken at a clock edge with push high
// and full low. Key events come out of a result queue port (empty/pop): the
// oldest event sits on o_key_number/o_pressed/o_last_event while empty is low
// and leaves at an edge with pop high. A scan gives zero to ROWS events in row
// order, the last one flagged with o_last_event.
// A scan passes from the scan queue into the evaluator's scan latch, is
// evaluated over all rows in state S_EVAL, and any events it yields are pushed
// into the result queue from state S_EMIT.
// The single evaluator takes a new scan only after all events of the last
// one are emitted, and it emits one event per cycle while the result queue
// has room.
// Scans of a column outside the matrix are taken and dropped.
// The debounce setting is written on the cfg channel (always ready).
// Reset clears all key state, both queues and sets the debounce to 7 ms.
// A stalled result side fills the result queue, then the scan queue, then
// raises full; no event is lost.
module key_matrix_debounce_scanner #(
    parameter int ROWS    = kmds_pkg::ROWS_DEF,
    parameter int COLUMNS = kmds_pkg::COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [kmds_pkg::COL_W-1:0]  i_column,
    input  logic [kmds_pkg::PIN_W-1:0]  i_row_pins,
    input  logic [kmds_pkg::TIME_W-1:0] i_now_ms,
    output logic                        empty,
    input  logic                        pop,
    output logic [kmds_pkg::KEY_W-1:0]  o_key_number,
    output logic                        o_pressed,
    output logic                        o_last_event,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kmds_pkg::DEB_W-1:0]  i_cfg_data
);
    import kmds_pkg::*;

    logic [DEB_W-1:0] r_deb;
    logic             w_cq_push;
    logic             w_cq_full;
    logic             w_cq_empty;
    logic             w_cq_pop;
    t_scan            w_cq_in;
    t_scan            w_cq_out;
    logic             w_ev_push;
    logic             w_ev_full;
    t_event           w_ev_in;
    t_event           w_ev_out;

    // Debounce setting register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_deb <= i_cfg_data;
        end
    end

    // Scan intake
    kmds_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .push       (push),
        .full       (full),
        .i_column   (i_column),
        .i_row_pins (i_row_pins),
        .i_now_ms   (i_now_ms),
        .i_q_full   (w_cq_full),
        .o_q_push   (w_cq_push),
        .o_q_data   (w_cq_in)
    );

    // Scan queue between front and back
    kmds_fifo #(
        .WIDTH ($bits(t_scan)),
        .DEPTH (QUEUE_DEPTH)
    ) u_scan_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cq_push),
        .i_data  (w_cq_in),
        .o_full  (w_cq_full),
        .i_pop   (w_cq_pop),
        .o_data  (w_cq_out),
        .o_empty (w_cq_empty)
    );

    // Debounce evaluation and event generation
    kmds_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_debounce_ms (r_deb),
        .i_q_empty     (w_cq_empty),
        .i_q_data      (w_cq_out),
        .o_q_pop       (w_cq_pop),
        .i_ev_full     (w_ev_full),
        .o_ev_push     (w_ev_push),
        .o_ev          (w_ev_in)
    );

    // Result queue
    kmds_fifo #(
        .WIDTH ($bits(t_event)),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ev_push),
        .i_data  (w_ev_in),
        .o_full  (w_ev_full),
        .i_pop   (pop),
        .o_data  (w_ev_out),
        .o_empty (empty)
    );

    assign o_key_number = w_ev_out.key_number;
    assign o_pressed    = w_ev_out.pressed;
    assign o_last_event = w_ev_out.last_event;

    // Events are never pushed into a full result queue
    a_no_event_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_push |-> !w_ev_full)
        else $error("event pushed into full result queue");

    // Only scans of columns inside the matrix reach the back end
    a_column_filtered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cq_push |-> ((COL_W+4)'(i_column) < (COL_W+4)'(COLUMNS)))
        else $error("out-of-range column queued");

    // No result is offered right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule
